@@ rtl/gha_pkg.sv @@
// ----------------------------------------------------------------------------
// gha_pkg
// shared codes, defaults and controller/datapath interface types
// ----------------------------------------------------------------------------
package gha_pkg;

    localparam int SLOT_COUNT_DEF = 1024;
    localparam int GEN_BITS_DEF   = 16;

    typedef enum logic [1:0] {
        REQ_CREATE  = 2'd0,
        REQ_DESTROY = 2'd1,
        REQ_CHECK   = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_ALIVE = 2'd2
    } stat_code_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic execute;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic result_pending;
    } dp_stat_t;

endpackage

@@ rtl/gha_ram.sv @@
// ----------------------------------------------------------------------------
// gha_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/gha_ctrl.sv @@
// ----------------------------------------------------------------------------
// gha_ctrl
// request sequencer: accept, then execute once the result register is free
// ----------------------------------------------------------------------------
module gha_ctrl
    import gha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output cmd_t     cmd,
    output logic     in_stall
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.accept  = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // result register free, or being emptied this cycle
                if (!stat.result_pending || !out_stall)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/gha_datapath.sv @@
// ----------------------------------------------------------------------------
// gha_datapath
// slot table, free list head and counters, result register
// ----------------------------------------------------------------------------
module gha_datapath
    import gha_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int GEN_BITS   = GEN_BITS_DEF,
    localparam int IDX_W = $clog2(SLOT_COUNT),
    localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output dp_stat_t            stat,
    input  logic [1:0]          req_type,
    input  logic [IDX_W-1:0]    handle_index,
    input  logic [GEN_BITS-1:0] handle_generation,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [1:0]          status,
    output logic [IDX_W-1:0]    new_index,
    output logic [GEN_BITS-1:0] new_generation
);

    // entry layout: live, generation, next free link
    localparam int ENT_W = 1 + GEN_BITS + IDX_W;

    // request capture
    req_t                req_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [GEN_BITS-1:0] gen_reg;

    // allocator state
    logic [IDX_W-1:0] free_head_reg, free_head_next;
    logic [CNT_W-1:0] free_count_reg, free_count_next;
    logic [CNT_W-1:0] slots_used_reg, slots_used_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    stat_code_t          status_reg, status_next;
    logic [IDX_W-1:0]    new_index_reg, new_index_next;
    logic [GEN_BITS-1:0] new_generation_reg, new_generation_next;

    // ram ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    logic                ent_live;
    logic [GEN_BITS-1:0] ent_gen;
    logic [IDX_W-1:0]    ent_next;
    logic [GEN_BITS-1:0] gen_inc;
    logic                alive;

    assign ram_raddr = (req_t'(req_type) == REQ_CREATE) ? free_head_reg : handle_index;

    gha_ram #(
        .WIDTH(ENT_W),
        .DEPTH(SLOT_COUNT)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd.accept),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign ent_live = ram_rdata[ENT_W-1];
    assign ent_gen  = ram_rdata[ENT_W-2 -: GEN_BITS];
    assign ent_next = ram_rdata[IDX_W-1:0];

    assign alive = (gen_reg != '0)
                && ({{(CNT_W-IDX_W){1'b0}}, idx_reg} < slots_used_reg)
                && ent_live
                && (ent_gen == gen_reg);

    always_comb
    begin
        gen_inc = ent_gen + GEN_BITS'(1);
        // generation zero is reserved
        if (gen_inc == '0)
        begin
            gen_inc = GEN_BITS'(1);
        end
    end

    always_comb
    begin
        free_head_next      = free_head_reg;
        free_count_next     = free_count_reg;
        slots_used_next     = slots_used_reg;
        ram_we              = 1'b0;
        ram_waddr           = idx_reg;
        ram_wdata           = ram_rdata;
        status_next         = status_reg;
        new_index_next      = new_index_reg;
        new_generation_next = new_generation_reg;
        out_valid_next      = out_valid_reg && out_stall;

        if (cmd.execute)
        begin
            out_valid_next      = 1'b1;
            status_next         = STAT_OK;
            new_index_next      = '0;
            new_generation_next = '0;
            case (req_reg)
                REQ_CREATE:
                begin
                    if (free_count_reg != '0)
                    begin
                        // pop the free list head
                        ram_we              = 1'b1;
                        ram_waddr           = free_head_reg;
                        ram_wdata           = {1'b1, ent_gen, ent_next};
                        free_head_next      = ent_next;
                        free_count_next     = free_count_reg - CNT_W'(1);
                        new_index_next      = free_head_reg;
                        new_generation_next = ent_gen;
                    end
                    else if (slots_used_reg < CNT_W'(SLOT_COUNT))
                    begin
                        // fresh slot
                        ram_we              = 1'b1;
                        ram_waddr           = slots_used_reg[IDX_W-1:0];
                        ram_wdata           = {1'b1, GEN_BITS'(1), {IDX_W{1'b0}}};
                        slots_used_next     = slots_used_reg + CNT_W'(1);
                        new_index_next      = slots_used_reg[IDX_W-1:0];
                        new_generation_next = GEN_BITS'(1);
                    end
                    else
                    begin
                        status_next = STAT_FULL;
                    end
                end
                REQ_DESTROY:
                begin
                    if (!alive)
                    begin
                        status_next = STAT_NOT_ALIVE;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = idx_reg;
                        ram_wdata       = {1'b0, gen_inc, free_head_reg};
                        free_head_next  = idx_reg;
                        free_count_next = free_count_reg + CNT_W'(1);
                    end
                end
                REQ_CHECK:
                begin
                    status_next = alive ? STAT_OK : STAT_NOT_ALIVE;
                end
                REQ_CLEAR:
                begin
                    slots_used_next = '0;
                    free_count_next = '0;
                    free_head_next  = '0;
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req_t'(req_type);
            idx_reg <= handle_index;
            gen_reg <= handle_generation;
        end
        status_reg         <= status_next;
        new_index_reg      <= new_index_next;
        new_generation_reg <= new_generation_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '0;
            free_count_reg <= '0;
            slots_used_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            slots_used_reg <= slots_used_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign stat.result_pending = out_valid_reg;
    assign out_valid           = out_valid_reg;
    assign status              = status_reg;
    assign new_index           = new_index_reg;
    assign new_generation      = new_generation_reg;

endmodule

@@ rtl/generational_handle_allocator_top.sv @@
// ----------------------------------------------------------------------------
// generational_handle_allocator_top
// generational handle allocator with lifo free list
// ----------------------------------------------------------------------------
// Each request beat (create, destroy, check alive, clear all) yields exactly
// one result beat. A request is handled as an accept step then an execute step:
// in the accept step the slot entry (live bit, generation, free link) is read
// from the single slot ram through its registered read port, addressed by the
// free list head for a create and by the handle index otherwise; in the execute
// step the entry, if changed, is written back and the result register loaded.
// Because of that read-modify-write on the one ram port pair, no new request is
// taken until the current one has executed. A request is taken while an earlier
// result still waits in the result register; it then holds in its execute step
// until that result beat leaves. Slot contents need no clearing after reset or
// clear: the fill count and free list keep unwritten entries from ever being used.
// ----------------------------------------------------------------------------
module generational_handle_allocator_top
    import gha_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int GEN_BITS   = GEN_BITS_DEF,
    localparam int IDX_W = $clog2(SLOT_COUNT)
) (
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic [IDX_W-1:0]    handle_index,
    input  logic [GEN_BITS-1:0] handle_generation,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [IDX_W-1:0]    new_index,
    output logic [GEN_BITS-1:0] new_generation
);

    // command and status between sequencer and datapath
    cmd_t     cmd;
    dp_stat_t stat;

    gha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_stall(out_stall),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    gha_datapath #(
        .SLOT_COUNT(SLOT_COUNT),
        .GEN_BITS  (GEN_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .req_type         (req_type),
        .handle_index     (handle_index),
        .handle_generation(handle_generation),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .status           (status),
        .new_index        (new_index),
        .new_generation   (new_generation)
    );

    // an accepted beat always occupies the block for its execute step
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("request accepted without an execute cycle");

    // a result only appears after a request has been in flight
    a_result_has_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall)
    ) else $error("result beat without a request");

    // handle fields are zero on a failed request
    a_fields_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_OK) |-> (new_index == '0 && new_generation == '0)
    ) else $error("handle fields set on a failed request");

    // a successful create at a nonzero index never hands out generation zero
    a_create_gen_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && new_index != '0) |-> (new_generation != '0)
    ) else $error("created handle with generation zero");

endmodule

@@ test/generational_handle_allocator_top_tb.sv @@
// ----------------------------------------------------------------------------
// generational_handle_allocator_top_tb
// self-checking bench for the handle allocator: a short table of directed
// requests, then well-formed create/destroy/check traffic mixed with stale and
// malformed handles and the odd clear; every result beat is compared against
// an in-bench model of the slot table, or a directed row's own answer, with
// random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module generational_handle_allocator_top_tb;
    import gha_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int GBITS        = GEN_BITS_DEF;
    localparam int IW           = $clog2(SLOTS);
    localparam int MIX_ITEMS    = 800;
    localparam int IDLE_PCT     = 20;
    localparam int PRESSURE_AT  = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int CALM_FROM    = 1000;
    localparam int CALM_TO      = 1600;
    localparam int DRAIN_CYCLES = 8;
    // watchdog bound for ~820 beats with pessimistic gaps and stalls,
    // plus the long hold
    localparam int CYCLE_LIMIT  = 80_000;

    typedef logic [IW-1:0]    slot_t;
    typedef logic [GBITS-1:0] gen_t;

    // one result beat as the block should present it
    typedef struct packed {
        stat_code_t st;
        slot_t      idx;
        gen_t       gen;
    } reply_t;

    // one row of the directed table; typed rows carry their own answer
    typedef struct packed {
        req_t   op;
        slot_t  idx;
        gen_t   gen;
        logic   typed;
        reply_t want;
    } plan_row_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    logic  [1:0] req_type;
    slot_t handle_index;
    gen_t  handle_generation;
    logic  out_valid;
    logic  out_stall;
    logic  [1:0] status;
    slot_t new_index;
    gen_t  new_generation;

    generational_handle_allocator_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .req_type          (req_type),
        .handle_index      (handle_index),
        .handle_generation (handle_generation),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .new_index         (new_index),
        .new_generation    (new_generation)
    );

    // ------------------------------------------------------------------
    // clock, reset, cycle counter and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // reset held low at the start, never again
    initial
    begin
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    int unsigned cycle_count = 0;
    logic        calm;
    reply_t      pending_replies [$];

    // a window in which neither side idles, so requests go in as fast as the block takes them
    assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_replies.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // slot table model
    // ------------------------------------------------------------------
    gen_t        gen_of  [SLOTS];
    logic        live_of [SLOTS];
    slot_t       link_of [SLOTS];
    int unsigned head_slot  = 0;
    int unsigned free_len   = 0;   // entries on the lifo free list
    int unsigned fill_cnt   = 0;   // fresh slots handed out since the last clear
    int unsigned high_water = 0;   // slots ever written since reset

    int unsigned op_count [4] = '{0, 0, 0, 0};
    int unsigned full_count     = 0;
    int unsigned wrap_count     = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;

    function automatic logic handle_live(slot_t i, gen_t g);
        if (g == '0 || i >= fill_cnt)
            return 1'b0;
        return live_of[i] && gen_of[i] == g;
    endfunction

    // works out the reply to one request and moves the table on
    function automatic reply_t alloc_step(req_t op, slot_t i, gen_t g);
        reply_t r;
        gen_t   bumped;
        r = '0;
        r.st = STAT_OK;
        case (op)
            REQ_CREATE:
            begin
                if (free_len > 0)
                begin
                    // most recently freed slot first, keeping its generation
                    r.idx = slot_t'(head_slot);
                    r.gen = gen_of[head_slot];
                    live_of[head_slot] = 1'b1;
                    head_slot = link_of[head_slot];
                    free_len--;
                end
                else if (fill_cnt < SLOTS)
                begin
                    r.idx = slot_t'(fill_cnt);
                    r.gen = gen_t'(1);
                    gen_of[fill_cnt]  = gen_t'(1);
                    live_of[fill_cnt] = 1'b1;
                    link_of[fill_cnt] = '0;
                    fill_cnt++;
                    if (fill_cnt > high_water)
                        high_water = fill_cnt;
                end
                else
                begin
                    r.st = STAT_FULL;
                    full_count++;
                end
            end
            REQ_DESTROY:
            begin
                if (!handle_live(i, g))
                    r.st = STAT_NOT_ALIVE;
                else
                begin
                    // generation zero is never handed out, so skip it
                    bumped = gen_of[i] + 1'b1;
                    if (bumped == '0)
                    begin
                        bumped = gen_t'(1);
                        wrap_count++;
                    end
                    gen_of[i]  = bumped;
                    live_of[i] = 1'b0;
                    link_of[i] = slot_t'(head_slot);
                    head_slot  = i;
                    free_len++;
                end
            end
            REQ_CHECK:
            begin
                if (!handle_live(i, g))
                    r.st = STAT_NOT_ALIVE;
            end
            default:
            begin
                fill_cnt  = 0;
                free_len  = 0;
                head_slot = 0;
            end
        endcase
        return r;
    endfunction

    // random live handle, searched from a random starting slot
    function automatic logic pick_live(output slot_t i);
        int unsigned start;
        i = '0;
        if (fill_cnt == 0)
            return 1'b0;
        start = $urandom_range(fill_cnt - 1, 0);
        for (int unsigned k = 0; k < fill_cnt; k++)
        begin
            i = slot_t'((start + k) % fill_cnt);
            if (live_of[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("[%0d] mismatch: %s", cycle_count, what);
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offers one request beat, holds it until taken, then records the reply
    // that it must produce
    task automatic issue(input req_t op, input slot_t i, input gen_t g,
                         input logic typed = 1'b0, input reply_t want = '0);
        reply_t r;
        while (!calm && $urandom_range(99, 0) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        req_type          <= op;
        handle_index      <= i;
        handle_generation <= g;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        r = alloc_step(op, i, g);
        op_count[op]++;
        if (typed)
            r = want;
        pending_replies = {pending_replies, r};
    endtask

    // one random request: mostly well-formed traffic on live handles, the
    // rest stale, zero or foreign generations and the odd clear; destroy,
    // check and clear only address slots that have been written at least once
    task automatic mix_item();
        int    roll;
        logic  have;
        slot_t i;
        gen_t  g;
        roll = $urandom_range(99, 0);
        have = pick_live(i);
        if (roll < 40 || high_water == 0)
            issue(REQ_CREATE, slot_t'($urandom), gen_t'($urandom));
        else if (roll < 65 && have)
            issue(REQ_DESTROY, i, gen_of[i]);
        else if (roll < 75 && have)
            issue(REQ_CHECK, i, gen_of[i]);
        else if (roll < 98)
        begin
            i = slot_t'($urandom_range(high_water - 1, 0));
            case ($urandom_range(3, 0))
                0: g = '0;
                1: g = gen_of[i];
                2: g = gen_of[i] + 1'b1;
                default: g = gen_t'($urandom);
            endcase
            issue($urandom_range(1, 0) ? REQ_DESTROY : REQ_CHECK, i, g);
        end
        else
            issue(REQ_CLEAR, slot_t'($urandom_range(high_water - 1, 0)),
                  gen_t'($urandom));
    endtask

    // directed opening: fresh slots, zero and stale generations, double
    // destroy, lifo reuse, clear, then handles beyond the fill count and fresh and reused slots
    plan_row_t plan [0:21] = '{
        '{REQ_CREATE,  0, 0,       1'b1, '{STAT_OK,        0, 1}},
        '{REQ_CREATE,  0, 0,       1'b1, '{STAT_OK,        1, 1}},
        '{REQ_CREATE,  0, 0,       1'b1, '{STAT_OK,        2, 1}},
        '{REQ_CHECK,   1, 1,       1'b1, '{STAT_OK,        0, 0}},
        '{REQ_CHECK,   1, 0,       1'b1, '{STAT_NOT_ALIVE, 0, 0}},
        '{REQ_CHECK,   1, 2,       1'b1, '{STAT_NOT_ALIVE, 0, 0}},
        '{REQ_DESTROY, 1, 1,       1'b1, '{STAT_OK,        0, 0}},
        '{REQ_CHECK,   1, 1,       1'b1, '{STAT_NOT_ALIVE, 0, 0}},
        '{REQ_DESTROY, 1, 1,       1'b1, '{STAT_NOT_ALIVE, 0, 0}},
        '{REQ_DESTROY, 0, 0,       1'b1, '{STAT_NOT_ALIVE, 0, 0}},
        '{REQ_DESTROY, 2, 1,       1'b1, '{STAT_OK,        0, 0}},
        '{REQ_CREATE,  0, 0,       1'b0, '{STAT_OK,        0, 0}},
        '{REQ_CREATE,  0, 0,       1'b0, '{STAT_OK,        0, 0}},
        '{REQ_CREATE,  0, 0,       1'b0, '{STAT_OK,        0, 0}},
        '{REQ_CHECK,   0, 16'hFFFF, 1'b1, '{STAT_NOT_ALIVE, 0, 0}},
        '{REQ_CLEAR,   0, 16'hFFFF, 1'b1, '{STAT_OK,        0, 0}},
        '{REQ_CHECK,   2, 2,       1'b1, '{STAT_NOT_ALIVE, 0, 0}},
        '{REQ_DESTROY, 3, 1,       1'b1, '{STAT_NOT_ALIVE, 0, 0}},
        '{REQ_CREATE,  0, 0,       1'b0, '{STAT_OK,        0, 0}},
        '{REQ_DESTROY, 0, 1,       1'b0, '{STAT_OK,        0, 0}},
        '{REQ_CREATE,  0, 0,       1'b0, '{STAT_OK,        0, 0}},
        '{REQ_CHECK,   0, 2,       1'b0, '{STAT_OK,        0, 0}}
    };

    initial
    begin : stimulus
        in_valid          <= 1'b0;
        req_type          <= REQ_CREATE;
        handle_index      <= '0;
        handle_generation <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (plan[k])
            issue(plan[k].op, plan[k].idx, plan[k].gen, plan[k].typed, plan[k].want);

        repeat (MIX_ITEMS)
            mix_item();
        in_valid <= 1'b0;

        // drain, then leave room for any stray beat to show up
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d requests: %0d create, %0d destroy, %0d check, %0d clear",
                 op_count[REQ_CREATE] + op_count[REQ_DESTROY] + op_count[REQ_CHECK]
                 + op_count[REQ_CLEAR], op_count[REQ_CREATE], op_count[REQ_DESTROY],
                 op_count[REQ_CHECK], op_count[REQ_CLEAR]);
        $display("%0d replies compared, table-full %0d, wraps %0d, slots ever used %0d",
                 results_seen, full_count, wrap_count, high_water);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stalls, one long hold-off so the block backs up
    // into its request channel, and the comparison of every beat
    // ------------------------------------------------------------------
    initial
    begin : result_side
        int     hold_left;
        logic   hold_done;
        reply_t want;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                results_seen++;
                if (pending_replies.size() == 0)
                    flag_mismatch($sformatf("unrequested beat: status %0d index %0d gen %0d",
                                            status, new_index, new_generation));
                else
                begin
                    want = pending_replies.pop_front();
                    if (status !== want.st)
                        flag_mismatch($sformatf("beat %0d status %0d, wanted %0d",
                                                results_seen, status, want.st));
                    if (new_index !== want.idx)
                        flag_mismatch($sformatf("beat %0d new_index %0d, wanted %0d",
                                                results_seen, new_index, want.idx));
                    if (new_generation !== want.gen)
                        flag_mismatch($sformatf("beat %0d new_generation %0d, wanted %0d",
                                                results_seen, new_generation, want.gen));
                end
            end
            if (!hold_done && results_seen >= PRESSURE_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99, 0) < IDLE_PCT);
        end
    end

endmodule

@@ generational_handle_allocator_top.f @@
rtl/gha_pkg.sv
rtl/gha_ram.sv
rtl/gha_ctrl.sv
rtl/gha_datapath.sv
rtl/generational_handle_allocator_top.sv
test/generational_handle_allocator_top_tb.sv
